/* rtl/rccl_pkg.sv */
// Shared constants and types for the ray color consistency loss block.
// Depends on nothing; used by the top level and the divider.
`default_nettype none
package rccl_pkg;

	// Hit storage capacity and index widths.
	localparam int MAX_HITS = 64;
	localparam int HIDX_W   = $clog2(MAX_HITS);
	localparam int HCNT_W   = $clog2(MAX_HITS + 1);

	// Q1.16 one, used for occupancy clamping and the first running product.
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// Divider operand widths: magnitude shifted by 16 over a 17-bit occupancy.
	localparam int DIV_W = 43;
	localparam int DVS_W = 17;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE  = 2'd2;

	// Request to the iterative divider.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	// Response from the iterative divider.
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

/* rtl/rccl_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rccl_pkg for operand widths and the request/response structs.
`default_nettype none
module rccl_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rccl_pkg::div_req_t req,
	output rccl_pkg::div_rsp_t      rsp
);
	import rccl_pkg::*;

	localparam int STEP_W = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_next;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial    = {rem_q, quo_q[DIV_W-1]};
		diff     = trial - {1'b0, dvs_q};
		ge       = trial >= {1'b0, dvs_q};
		rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

/* rtl/ray_color_consistency_loss.sv */
// Top level of the ray color consistency loss block: hit memory, sequencer, datapath.
// Depends on rccl_pkg and instantiates the iterative divider rccl_div.
`default_nettype none
// The block takes the hits of one ray in order and, after the hit marked last_hit,
// returns one result per stored hit in reverse order, each with the ray's expected
// cost. Each hit enters through an accept and the arithmetic states M1, M2 and M3,
// during which in_stall is high. After the last hit come the states BG1 and BG2 for
// the background cost, a first reverse pass over the hit memory (read, multiply and
// accumulate per hit) that sums the cost terms, one setup state, and a second reverse
// pass that per hit does a memory read, a multiply, an accumulate, a wait on the
// bit-serial occupancy divider (skipped when occupancy is zero) and then offers the
// result, held while out_stall is high. All hit state lives in one 64-entry memory
// with registered reads; no clearing pass follows reset.
module ray_color_consistency_loss (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [rccl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                    cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [15:0]                    observed_red,
	input  wire logic [15:0]                    observed_green,
	input  wire logic [15:0]                    observed_blue,
	input  wire logic [16:0]                    occupancy,
	input  wire logic [15:0]                    predicted_red,
	input  wire logic [15:0]                    predicted_green,
	input  wire logic [15:0]                    predicted_blue,
	input  wire logic [23:0]                    cell_id,
	input  wire logic                           last_hit,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [23:0]                         result_cell,
	output logic signed [31:0]                  grad_red,
	output logic signed [31:0]                  grad_green,
	output logic signed [31:0]                  grad_blue,
	output logic signed [31:0]                  grad_occupancy,
	output logic signed [31:0]                  expected_cost,
	output logic                                last_result
);
	import rccl_pkg::*;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_M1    = 4'd1;
	localparam logic [3:0] ST_M2    = 4'd2;
	localparam logic [3:0] ST_M3    = 4'd3;
	localparam logic [3:0] ST_BG1   = 4'd4;
	localparam logic [3:0] ST_BG2   = 4'd5;
	localparam logic [3:0] ST_RD    = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_ACC   = 4'd8;
	localparam logic [3:0] ST_BINIT = 4'd9;
	localparam logic [3:0] ST_DIV   = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	// One memory row holds everything stored for a hit.
	typedef struct packed {
		logic [16:0]        occ;
		logic [16:0]        prod;
		logic [17:0]        cost;
		logic [23:0]        cell_idx;
		logic signed [31:0] gr;
		logic signed [31:0] gg;
		logic signed [31:0] gb;
	} row_t;

	row_t mem_q [MAX_HITS];
	row_t rd_q;
	row_t wr_row;

	logic [3:0]        state_q;
	logic [15:0]       bg_r_q, bg_g_q, bg_b_q;
	logic [15:0]       obs_r_q, obs_g_q, obs_b_q;
	logic [15:0]       pred_r_q, pred_g_q, pred_b_q;
	logic [16:0]       occ_q;
	logic [23:0]       cell_q;
	logic              last_q;
	logic [HCNT_W-1:0] hit_count_q;
	logic [16:0]       prev_q;
	logic [HIDX_W-1:0] h_q;
	logic              pass_b_q;
	logic [17:0]       bg_cost_q;
	logic [17:0]       cnext_q;
	logic signed [31:0] acc_q;
	logic signed [36:0] term_q;
	logic signed [31:0] expected_q;
	logic signed [31:0] og_q;

	// Pipeline registers of the hit entry arithmetic.
	logic signed [16:0] d_r_s1, d_g_s1, d_b_s1;
	logic [32:0]        sq_r_s1, sq_g_s1, sq_b_s1;
	logic [33:0]        prod_full_s1;
	logic signed [34:0] grad_r_s2, grad_g_s2, grad_b_s2;
	logic [17:0]        cost_s2;
	logic [16:0]        prod_s2;

	logic               in_accept;
	logic               store_ok;
	logic [15:0]        sa_r, sa_g, sa_b;
	logic signed [16:0] d_r_c, d_g_c, d_b_c;
	logic signed [33:0] sq_r_c, sq_g_c, sq_b_c;
	logic [34:0]        sq_sum;
	logic [34:0]        sq_rnd;
	logic [17:0]        cost_c;
	logic [33:0]        prod_rnd;
	logic [16:0]        prod_c;
	logic [16:0]        pass_c;
	logic signed [34:0] gr_rnd, gg_rnd, gb_rnd;
	logic signed [18:0] cost_diff;
	logic signed [36:0] term_c;
	logic signed [36:0] term_rnd;
	logic signed [31:0] acc_new;
	logic signed [31:0] mag32;
	logic [DIV_W-1:0]   q_c;
	logic signed [31:0] og_c;
	logic [HIDX_W-1:0]  h_last;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign store_ok  = hit_count_q < HCNT_W'(MAX_HITS);
	assign h_last    = HIDX_W'(hit_count_q - 1'b1);

	// Color differences and squares; the background replaces the prediction
	// when the ray's background cost is formed.
	always_comb begin
		sa_r   = (state_q == ST_BG1) ? bg_r_q : pred_r_q;
		sa_g   = (state_q == ST_BG1) ? bg_g_q : pred_g_q;
		sa_b   = (state_q == ST_BG1) ? bg_b_q : pred_b_q;
		d_r_c  = $signed({1'b0, sa_r}) - $signed({1'b0, obs_r_q});
		d_g_c  = $signed({1'b0, sa_g}) - $signed({1'b0, obs_g_q});
		d_b_c  = $signed({1'b0, sa_b}) - $signed({1'b0, obs_b_q});
		sq_r_c = d_r_c * d_r_c;
		sq_g_c = d_g_c * d_g_c;
		sq_b_c = d_b_c * d_b_c;
	end

	// Half the squared distance, rounded to Q16.
	always_comb begin
		sq_sum = {2'b0, sq_r_s1} + {2'b0, sq_g_s1} + {2'b0, sq_b_s1};
		sq_rnd = sq_sum + 35'd65536;
		cost_c = sq_rnd[34:17];
	end

	// Running product, pass-through weight and rounded color gradients.
	always_comb begin
		prod_rnd = prod_full_s1 + 34'd32768;
		prod_c   = prod_rnd[32:16];
		pass_c   = prev_q - prod_c;
		gr_rnd   = grad_r_s2 + 35'sd32768;
		gg_rnd   = grad_g_s2 + 35'sd32768;
		gb_rnd   = grad_b_s2 + 35'sd32768;
		wr_row.occ      = occ_q;
		wr_row.prod     = prod_s2;
		wr_row.cost     = cost_s2;
		wr_row.cell_idx = cell_q;
		wr_row.gr       = {{13{gr_rnd[34]}}, gr_rnd[34:16]};
		wr_row.gg       = {{13{gg_rnd[34]}}, gg_rnd[34:16]};
		wr_row.gb       = {{13{gb_rnd[34]}}, gb_rnd[34:16]};
	end

	// Reverse pass: cost step times product, rounded and accumulated.
	always_comb begin
		cost_diff = $signed({1'b0, cnext_q}) - $signed({1'b0, rd_q.cost});
		term_c    = cost_diff * $signed({1'b0, rd_q.prod});
		term_rnd  = term_q + 37'sd32768;
		acc_new   = acc_q + {{11{term_rnd[36]}}, term_rnd[36:16]};
		mag32     = acc_new[31] ? -acc_new : acc_new;
	end

	// Occupancy gradient request and saturation of the quotient.
	always_comb begin
		div_req.start    = (state_q == ST_ACC) && pass_b_q && (rd_q.occ != '0);
		div_req.dividend = {mag32[26:0], 16'b0} + {27'b0, rd_q.occ[16:1]};
		div_req.divisor  = rd_q.occ;
		q_c = div_rsp.quotient;
		if (acc_q[31]) begin
			og_c = (q_c > 43'h0_8000_0000) ? 32'sh8000_0000 : -$signed(q_c[31:0]);
		end else begin
			og_c = (q_c > 43'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_c[31:0]);
		end
	end

	rccl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration registers; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_r_q <= '0;
			bg_g_q <= '0;
			bg_b_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_BG_RED:   bg_r_q <= cfg_data;
				CFG_BG_GREEN: bg_g_q <= cfg_data;
				CFG_BG_BLUE:  bg_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hit memory. Writes happen only while a hit enters and reads only in the
	// reverse passes, so the two never touch the same entry in one cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_M3 && store_ok) begin
			mem_q[hit_count_q[HIDX_W-1:0]] <= wr_row;
		end
		if (state_q == ST_RD) begin
			rd_q <= mem_q[h_q];
		end
	end

	// Sequencer and its control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hit_count_q <= '0;
			prev_q      <= ONE_Q16;
			h_q         <= '0;
			pass_b_q    <= 1'b0;
			acc_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) state_q <= ST_M1;
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: begin
					if (store_ok) begin
						hit_count_q <= hit_count_q + 1'b1;
						prev_q      <= prod_s2;
					end
					state_q <= last_q ? ST_BG1 : ST_IDLE;
				end
				ST_BG1: state_q <= ST_BG2;
				ST_BG2: begin
					h_q      <= h_last;
					pass_b_q <= 1'b0;
					acc_q    <= '0;
					state_q  <= ST_RD;
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					acc_q <= acc_new;
					if (!pass_b_q) begin
						if (h_q == '0) begin
							state_q <= ST_BINIT;
						end else begin
							h_q     <= h_q - 1'b1;
							state_q <= ST_RD;
						end
					end else if (rd_q.occ == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_BINIT: begin
					acc_q    <= '0;
					h_q      <= h_last;
					pass_b_q <= 1'b1;
					state_q  <= ST_RD;
				end
				ST_DIV: begin
					if (div_rsp.done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (h_q == '0) begin
							hit_count_q <= '0;
							prev_q      <= ONE_Q16;
							acc_q       <= '0;
							state_q     <= ST_IDLE;
						end else begin
							h_q     <= h_q - 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; they need no reset.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			obs_r_q  <= observed_red;
			obs_g_q  <= observed_green;
			obs_b_q  <= observed_blue;
			pred_r_q <= predicted_red;
			pred_g_q <= predicted_green;
			pred_b_q <= predicted_blue;
			occ_q    <= (occupancy > ONE_Q16) ? ONE_Q16 : occupancy;
			cell_q   <= cell_id;
			last_q   <= last_hit;
		end
		if (state_q == ST_M1 || state_q == ST_BG1) begin
			d_r_s1  <= d_r_c;
			d_g_s1  <= d_g_c;
			d_b_s1  <= d_b_c;
			sq_r_s1 <= sq_r_c[32:0];
			sq_g_s1 <= sq_g_c[32:0];
			sq_b_s1 <= sq_b_c[32:0];
		end
		if (state_q == ST_M1) begin
			prod_full_s1 <= prev_q * occ_q;
		end
		if (state_q == ST_M2) begin
			prod_s2   <= prod_c;
			cost_s2   <= cost_c;
			grad_r_s2 <= $signed({1'b0, pass_c}) * d_r_s1;
			grad_g_s2 <= $signed({1'b0, pass_c}) * d_g_s1;
			grad_b_s2 <= $signed({1'b0, pass_c}) * d_b_s1;
		end
		if (state_q == ST_BG2) begin
			bg_cost_q <= cost_c;
			cnext_q   <= cost_c;
		end
		if (state_q == ST_MUL) begin
			term_q  <= term_c;
			cnext_q <= rd_q.cost;
		end
		if (state_q == ST_BINIT) begin
			// The cost of the first hit is left in cnext_q by the first pass.
			expected_q <= acc_q + $signed({14'b0, cnext_q});
			cnext_q    <= bg_cost_q;
		end
		if (state_q == ST_ACC && pass_b_q && rd_q.occ == '0) begin
			og_q <= '0;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			og_q <= og_c;
		end
	end

	// Result item, held steady while offered.
	assign out_valid      = state_q == ST_OUT;
	assign result_cell    = rd_q.cell_idx;
	assign grad_red       = rd_q.gr;
	assign grad_green     = rd_q.gg;
	assign grad_blue      = rd_q.gb;
	assign grad_occupancy = og_q;
	assign expected_cost  = expected_q;
	assign last_result    = h_q == '0;

endmodule
`default_nettype wire

/* rtl/rccl_checker.sv */
// Port-level checker for the ray color consistency loss block, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module rccl_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] grad_occupancy,
	input wire logic        last_result
);

	// An accepted item keeps the input side busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken right after an accepted item");

	// Results are only offered while no new item can enter.
	a_out_excludes_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result offered while input is open");

	// The final result of a ray is followed by a gap.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_result |=> !out_valid)
		else $error("result offered right after the final result");

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(grad_occupancy))
		else $error("stalled result changed");

endmodule

bind ray_color_consistency_loss rccl_props u_rccl_props (.*);
`default_nettype wire
